// ===== rtl/inverted_page_table_fault_flush_core_macros.svh =====
// Assertion macros for the checker of the page table core.
`ifndef INVERTED_PAGE_TABLE_FAULT_FLUSH_CORE_MACROS_SVH
`define INVERTED_PAGE_TABLE_FAULT_FLUSH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPTFF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IPTFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table core: next-cycle check failed");

`endif

// ===== rtl/iptff_pkg.sv =====
// Types and constants of the inverted page table core.
package iptff_pkg;

  localparam int PID_W   = 2;
  localparam int PAGE_W  = 20;
  localparam int LIMIT_W = 16;
  localparam int FCNT_W  = 17;
  localparam int TOT_W   = 32;
  localparam int FI_W    = 6;
  localparam int WBO_W   = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4;
  localparam logic [WBO_W-1:0]   WB_SAT      = 7'd127;

  // Command codes.
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Process identifiers; owner zero marks a frame that was never used.
  localparam logic [PID_W-1:0] PID_NONE = 2'd0;
  localparam logic [PID_W-1:0] PID_ONE  = 2'd1;
  localparam logic [PID_W-1:0] PID_TWO  = 2'd2;

  // One frame of the table as held in memory.
  typedef struct packed {
    logic              valid;
    logic [PID_W-1:0]  owner;
    logic              dirty;
    logic [PAGE_W-1:0] page;
  } iptff_entry_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_REPLY = 6'b100000
  } iptff_state_t;

endpackage

// ===== rtl/inverted_page_table_fault_flush_core.sv =====
// Inverted page table core: frame memory, sequencer and running totals.
// States per request: a hit is SCAN then REPLY, a finish FLUSH then REPLY, a plain fault
// SCAN, LOAD, REPLY, a flushing fault SCAN, FLUSH, LOAD, REPLY; a bad process id only REPLY.
// One request is in flight at a time (busy high); the next may be accepted in the result cycle.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// After reset a clearing pass over every frame empties the memory while busy is high.
module inverted_page_table_fault_flush_core
  import iptff_pkg::*;
#(
  parameter int FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [PID_W-1:0]   in_process_id,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic               in_is_write,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_fault_limit,
  output logic               out_valid,
  output logic               out_hit,
  output logic               out_page_fault,
  output logic               out_flushed,
  output logic               out_loaded,
  output logic [FI_W-1:0]    out_frame_index,
  output logic [WBO_W-1:0]   out_writebacks_now,
  output logic [TOT_W-1:0]   out_total_writes,
  output logic [TOT_W-1:0]   out_total_reads,
  output logic [TOT_W-1:0]   out_total_faults
);

  localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int WBW = $clog2(FRAMES + 1);
  localparam int XW  = (IW > FI_W) ? IW : FI_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

  // Frame memory with registered read data.
  iptff_entry_t mem_q [FRAMES];
  logic         mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  iptff_entry_t mem_wdata;

  iptff_state_t state_r, state_nxt;
  logic [IW-1:0]  addr_r, addr_nxt;
  logic           issue_r, issue_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]  rd_addr_r, rd_addr_nxt;
  iptff_entry_t   rd_data_r;

  logic              cmd_r, cmd_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              wr_r, wr_nxt;
  logic              acc_r, acc_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     hit_idx_r, hit_idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic [WBW-1:0]    wb_r, wb_nxt;
  logic              flush_will_r, flush_will_nxt;

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [FCNT_W-1:0]  fc0_r, fc0_nxt, fc1_r, fc1_nxt;
  logic [TOT_W-1:0]   wt_r, wt_nxt, rt_r, rt_nxt, ft_r, ft_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_fault_r, out_fault_nxt;
  logic               out_flushed_r, out_flushed_nxt;
  logic               out_loaded_r, out_loaded_nxt;
  logic [FI_W-1:0]    out_fi_r, out_fi_nxt;
  logic [WBO_W-1:0]   out_wb_r, out_wb_nxt;

  logic [FCNT_W-1:0]  fc_in_inc, fc_item_inc;
  logic               pid_own, free_cand, last_rd;
  logic [XW-1:0]      fi_ext;
  logic [TOT_W-1:0]   wb_wide;

  // Memory: one write and one read a cycle, never to the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem_q[mem_raddr];
    end
  end

  // Fault counts incremented, for the incoming request and the held one.
  assign fc_in_inc   = (in_process_id[1] ? fc1_r : fc0_r) + FCNT_W'(1);
  assign fc_item_inc = (pid_r[1] ? fc1_r : fc0_r) + FCNT_W'(1);

  // Properties of the entry just read.
  assign pid_own   = rd_data_r.valid && (rd_data_r.owner == pid_r);
  assign free_cand = (!rd_data_r.valid &&
                      (rd_data_r.owner == pid_r || rd_data_r.owner == PID_NONE)) ||
                     (flush_will_r && pid_own);
  assign last_rd   = (rd_addr_r == LAST_IDX);
  assign wb_wide   = TOT_W'(wb_r);

  // Sequencer and read-modify-write datapath.
  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    issue_nxt       = issue_r;
    rd_pend_nxt     = 1'b0;
    rd_addr_nxt     = rd_addr_r;
    cmd_nxt         = cmd_r;
    pid_nxt         = pid_r;
    page_nxt        = page_r;
    wr_nxt          = wr_r;
    acc_nxt         = acc_r;
    found_nxt       = found_r;
    hit_idx_nxt     = hit_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    wb_nxt          = wb_r;
    flush_will_nxt  = flush_will_r;
    limit_nxt       = limit_r;
    fc0_nxt         = fc0_r;
    fc1_nxt         = fc1_r;
    wt_nxt          = wt_r;
    rt_nxt          = rt_r;
    ft_nxt          = ft_r;
    out_valid_nxt   = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_fault_nxt   = out_fault_r;
    out_flushed_nxt = out_flushed_r;
    out_loaded_nxt  = out_loaded_r;
    out_fi_nxt      = out_fi_r;
    out_wb_nxt      = out_wb_r;
    fi_ext          = '0;
    mem_we          = 1'b0;
    mem_waddr       = rd_addr_r;
    mem_wdata       = rd_data_r;
    mem_re          = 1'b0;
    mem_raddr       = addr_r;

    // Configuration register write.
    if (cfg_valid) begin
      limit_nxt = cfg_fault_limit;
    end

    // Sweep reads, one entry a cycle.
    if ((state_r == ST_SCAN || state_r == ST_FLUSH) && issue_r) begin
      mem_re      = 1'b1;
      rd_pend_nxt = 1'b1;
      rd_addr_nxt = addr_r;
      if (addr_r == LAST_IDX) begin
        issue_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + IW'(1);
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = '0;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + IW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd_nxt        = in_cmd;
          pid_nxt        = in_process_id;
          page_nxt       = in_page_number;
          wr_nxt         = in_is_write;
          acc_nxt        = (in_cmd == CMD_ACCESS) &&
                           (in_process_id == PID_ONE || in_process_id == PID_TWO);
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          hit_idx_nxt    = '0;
          free_idx_nxt   = '0;
          wb_nxt         = '0;
          flush_will_nxt = fc_in_inc > FCNT_W'(limit_r);
          addr_nxt       = '0;
          issue_nxt      = 1'b1;
          if (in_cmd == CMD_FINISH) begin
            state_nxt = ST_FLUSH;
          end else if (in_process_id == PID_ONE || in_process_id == PID_TWO) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_REPLY;
          end
        end
      end

      // Lookup pass: also counts the process's dirty frames and finds a free frame.
      ST_SCAN: begin
        if (rd_pend_r) begin
          if (pid_own && rd_data_r.page == page_r) begin
            if (!found_r) begin
              hit_idx_nxt = rd_addr_r;
            end
            found_nxt = 1'b1;
            if (wr_r) begin
              mem_we          = 1'b1;
              mem_wdata.dirty = 1'b1;
            end
          end
          if (pid_own && rd_data_r.dirty) begin
            wb_nxt = wb_r + WBW'(1);
          end
          if (!free_found_r && free_cand) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = rd_addr_r;
          end
          if (last_rd) begin
            if (found_nxt) begin
              wb_nxt    = '0;
              state_nxt = ST_REPLY;
            end else if (flush_will_r) begin
              addr_nxt  = '0;
              issue_nxt = 1'b1;
              state_nxt = ST_FLUSH;
            end else begin
              wb_nxt    = '0;
              state_nxt = ST_LOAD;
            end
          end
        end
      end

      // Invalidate pass: every frame on finish, else the faulting process's.
      ST_FLUSH: begin
        if (rd_pend_r) begin
          if (rd_data_r.valid && (cmd_r == CMD_FINISH || rd_data_r.owner == pid_r)) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
            if (cmd_r == CMD_FINISH && rd_data_r.dirty) begin
              wb_nxt = wb_r + WBW'(1);
            end
          end
          if (last_rd) begin
            state_nxt = (cmd_r == CMD_FINISH) ? ST_REPLY : ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        if (free_found_r) begin
          mem_we          = 1'b1;
          mem_waddr       = free_idx_r;
          mem_wdata.valid = 1'b1;
          mem_wdata.owner = pid_r;
          mem_wdata.dirty = wr_r;
          mem_wdata.page  = page_r;
        end
        state_nxt = ST_REPLY;
      end

      // Result and counter update.
      ST_REPLY: begin
        out_hit_nxt     = acc_r && found_r;
        out_fault_nxt   = acc_r && !found_r;
        out_flushed_nxt = acc_r && !found_r && flush_will_r;
        out_loaded_nxt  = acc_r && !found_r && free_found_r;
        if (acc_r && found_r) begin
          fi_ext = XW'(hit_idx_r);
        end else if (acc_r && free_found_r) begin
          fi_ext = XW'(free_idx_r);
        end
        out_fi_nxt = fi_ext[FI_W-1:0];
        out_wb_nxt = (wb_wide > TOT_W'(WB_SAT)) ? WB_SAT : WBO_W'(wb_r);
        wt_nxt     = wt_r + wb_wide;
        if (acc_r && !found_r) begin
          ft_nxt = ft_r + TOT_W'(1);
          rt_nxt = rt_r + TOT_W'(1);
          if (pid_r[1]) begin
            fc1_nxt = flush_will_r ? FCNT_W'(1) : fc_item_inc;
          end else begin
            fc0_nxt = flush_will_r ? FCNT_W'(1) : fc_item_inc;
          end
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      issue_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      limit_r     <= LIMIT_RESET;
      fc0_r       <= '0;
      fc1_r       <= '0;
      wt_r        <= '0;
      rt_r        <= '0;
      ft_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      issue_r     <= issue_nxt;
      rd_pend_r   <= rd_pend_nxt;
      limit_r     <= limit_nxt;
      fc0_r       <= fc0_nxt;
      fc1_r       <= fc1_nxt;
      wt_r        <= wt_nxt;
      rt_r        <= rt_nxt;
      ft_r        <= ft_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    rd_addr_r     <= rd_addr_nxt;
    cmd_r         <= cmd_nxt;
    pid_r         <= pid_nxt;
    page_r        <= page_nxt;
    wr_r          <= wr_nxt;
    acc_r         <= acc_nxt;
    found_r       <= found_nxt;
    hit_idx_r     <= hit_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    wb_r          <= wb_nxt;
    flush_will_r  <= flush_will_nxt;
    out_hit_r     <= out_hit_nxt;
    out_fault_r   <= out_fault_nxt;
    out_flushed_r <= out_flushed_nxt;
    out_loaded_r  <= out_loaded_nxt;
    out_fi_r      <= out_fi_nxt;
    out_wb_r      <= out_wb_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_page_fault     = out_fault_r;
  assign out_flushed        = out_flushed_r;
  assign out_loaded         = out_loaded_r;
  assign out_frame_index    = out_fi_r;
  assign out_writebacks_now = out_wb_r;
  assign out_total_writes   = wt_r;
  assign out_total_reads    = rt_r;
  assign out_total_faults   = ft_r;

endmodule

// ===== rtl/iptff_checker.sv =====
// Port-level checker of the page table core and its bind.
`include "inverted_page_table_fault_flush_core_macros.svh"

module iptff_checker
  import iptff_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_hit,
  input logic               out_page_fault,
  input logic               out_loaded,
  input logic [WBO_W-1:0]   out_writebacks_now,
  input logic [TOT_W-1:0]   out_total_faults,
  input logic [TOT_W-1:0]   out_total_reads
);

  // An accepted request keeps the block busy on the next cycle.
  `IPTFF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // Each request gives a single one-cycle result strobe.
  `IPTFF_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

  // A fault advances the fault total by exactly one over the previous cycle.
  `IPTFF_ASSERT_NOW(a_fault_count, out_valid && out_page_fault,
                    out_total_faults == $past(out_total_faults) + 32'd1)

  // A hit loads nothing and writes nothing back.
  `IPTFF_ASSERT_NOW(a_hit_clean, out_valid && out_hit,
                    !out_page_fault && !out_loaded && out_writebacks_now == 7'd0 &&
                    out_total_reads == $past(out_total_reads))

endmodule

bind inverted_page_table_fault_flush_core iptff_checker u_iptff_checker (.*);

// ===== tb/sv/inverted_page_table_fault_flush_core_tb.sv =====
// Self-checking testbench for the inverted page table core with fault-limit flushing.
module inverted_page_table_fault_flush_core_tb;
  import iptff_pkg::*;

  localparam int FRAMES = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int REPORT_LINES = 40;
  localparam logic [PID_W-1:0] PID_BAD = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 90;

  // One expected result of the table.
  typedef struct {
    logic              hit;
    logic              page_fault;
    logic              flushed;
    logic              loaded;
    logic [FI_W-1:0]   frame_index;
    logic [WBO_W-1:0]  writebacks_now;
    logic [TOT_W-1:0]  total_writes;
    logic [TOT_W-1:0]  total_reads;
    logic [TOT_W-1:0]  total_faults;
  } table_outcome_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_cmd = CMD_ACCESS;
  logic [PID_W-1:0]   in_process_id = PID_NONE;
  logic [PAGE_W-1:0]  in_page_number = '0;
  logic               in_is_write = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_fault_limit = '0;
  logic               out_valid;
  logic               out_hit;
  logic               out_page_fault;
  logic               out_flushed;
  logic               out_loaded;
  logic [FI_W-1:0]    out_frame_index;
  logic [WBO_W-1:0]   out_writebacks_now;
  logic [TOT_W-1:0]   out_total_writes;
  logic [TOT_W-1:0]   out_total_reads;
  logic [TOT_W-1:0]   out_total_faults;

  // Shadow copy of the frame table, the fault counters and the totals.
  logic [PID_W-1:0]   shadow_owner [FRAMES];
  logic [PAGE_W-1:0]  shadow_page  [FRAMES];
  logic               shadow_dirty [FRAMES];
  logic               shadow_valid [FRAMES];
  logic [FCNT_W-1:0]  shadow_faults [2];
  logic [LIMIT_W-1:0] shadow_limit;
  logic [TOT_W-1:0]   shadow_writes;
  logic [TOT_W-1:0]   shadow_reads;
  logic [TOT_W-1:0]   shadow_fault_total;

  table_outcome_t pending_outcomes [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  inverted_page_table_fault_flush_core #(
    .FRAMES(FRAMES)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_process_id     (in_process_id),
    .in_page_number    (in_page_number),
    .in_is_write       (in_is_write),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_fault_limit   (cfg_fault_limit),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_page_fault    (out_page_fault),
    .out_flushed       (out_flushed),
    .out_loaded        (out_loaded),
    .out_frame_index   (out_frame_index),
    .out_writebacks_now(out_writebacks_now),
    .out_total_writes  (out_total_writes),
    .out_total_reads   (out_total_reads),
    .out_total_faults  (out_total_faults)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abandon the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("inverted_page_table_fault_flush_core: mismatch");
      $finish;
    end
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input logic [TOT_W-1:0] got,
                                 input logic [TOT_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Puts the shadow table into its post-reset state.
  function automatic void clear_shadow_table();
    int j;
    for (j = 0; j < FRAMES; j++) begin
      shadow_owner[j] = PID_NONE;
      shadow_page[j]  = '0;
      shadow_dirty[j] = 1'b0;
      shadow_valid[j] = 1'b0;
    end
    shadow_faults[0]   = '0;
    shadow_faults[1]   = '0;
    shadow_limit       = LIMIT_RESET;
    shadow_writes      = '0;
    shadow_reads       = '0;
    shadow_fault_total = '0;
  endfunction

  // Applies one request to the shadow table and returns the result it should give.
  function automatic table_outcome_t apply_page_access(input logic cmd,
                                                      input logic [PID_W-1:0] pid,
                                                      input logic [PAGE_W-1:0] page,
                                                      input logic wr);
    table_outcome_t res;
    int j;
    int wb;
    int slot;
    bit found;
    int p;
    res.hit = 1'b0;
    res.page_fault = 1'b0;
    res.flushed = 1'b0;
    res.loaded = 1'b0;
    slot = 0;
    wb = 0;
    found = 1'b0;
    if (cmd == CMD_FINISH) begin
      // Finish: every valid frame is written back if dirty and dropped.
      for (j = 0; j < FRAMES; j++) begin
        if (shadow_valid[j]) begin
          if (shadow_dirty[j]) wb++;
          shadow_valid[j] = 1'b0;
        end
      end
    end else if (pid == PID_ONE || pid == PID_TWO) begin
      // Look the page up among the valid frames of this process.
      for (j = 0; j < FRAMES; j++) begin
        if (shadow_valid[j] && shadow_owner[j] == pid && shadow_page[j] == page) begin
          if (wr) shadow_dirty[j] = 1'b1;
          if (!found) slot = j;
          found = 1'b1;
        end
      end
      if (found) begin
        res.hit = 1'b1;
      end else begin
        p = (pid == PID_ONE) ? 0 : 1;
        res.page_fault = 1'b1;
        shadow_fault_total++;
        shadow_reads++;
        shadow_faults[p] = shadow_faults[p] + 1'b1;
        // Past the limit the process loses all of its frames.
        if (shadow_faults[p] > shadow_limit) begin
          res.flushed = 1'b1;
          for (j = 0; j < FRAMES; j++) begin
            if (shadow_owner[j] == pid && shadow_valid[j]) begin
              if (shadow_dirty[j]) wb++;
              shadow_valid[j] = 1'b0;
            end
          end
          shadow_faults[p] = FCNT_W'(1);
        end
        // Load into the first free frame of this process or a never used one.
        for (j = 0; j < FRAMES; j++) begin
          if (!res.loaded && !shadow_valid[j] &&
              (shadow_owner[j] == pid || shadow_owner[j] == PID_NONE)) begin
            shadow_owner[j] = pid;
            shadow_page[j]  = page;
            shadow_valid[j] = 1'b1;
            shadow_dirty[j] = wr;
            res.loaded = 1'b1;
            slot = j;
          end
        end
      end
    end
    shadow_writes = shadow_writes + TOT_W'(wb);
    res.frame_index    = slot[FI_W-1:0];
    res.writebacks_now = (wb > 127) ? WB_SAT : wb[WBO_W-1:0];
    res.total_writes   = shadow_writes;
    res.total_reads    = shadow_reads;
    res.total_faults   = shadow_fault_total;
    return res;
  endfunction

  // Idle time before a request: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 180);
  endfunction

  // Sends one request and records the result it should produce.
  task automatic send_request(input logic cmd, input logic [PID_W-1:0] pid,
                              input logic [PAGE_W-1:0] page, input logic wr);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_process_id  <= pid;
    in_page_number <= page;
    in_is_write    <= wr;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(apply_page_access(cmd, pid, page, wr));
  endtask

  // Stops issuing and waits until every result is in, then lets the block settle.
  task automatic wait_quiet(input int settle);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes the fault limit while the table is idle.
  task automatic set_fault_limit(input logic [LIMIT_W-1:0] value);
    wait_quiet(4);
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_fault_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_limit = value;
    @(posedge clk);
  endtask

  // Each strobed result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    table_outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, frame_index", TOT_W'(out_frame_index), '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_hit !== want.hit)
          report_mismatch("hit", TOT_W'(out_hit), TOT_W'(want.hit));
        if (out_page_fault !== want.page_fault)
          report_mismatch("page_fault", TOT_W'(out_page_fault), TOT_W'(want.page_fault));
        if (out_flushed !== want.flushed)
          report_mismatch("flushed", TOT_W'(out_flushed), TOT_W'(want.flushed));
        if (out_loaded !== want.loaded)
          report_mismatch("loaded", TOT_W'(out_loaded), TOT_W'(want.loaded));
        if (out_frame_index !== want.frame_index)
          report_mismatch("frame_index", TOT_W'(out_frame_index), TOT_W'(want.frame_index));
        if (out_writebacks_now !== want.writebacks_now)
          report_mismatch("writebacks_now", TOT_W'(out_writebacks_now),
                          TOT_W'(want.writebacks_now));
        if (out_total_writes !== want.total_writes)
          report_mismatch("total_writes", out_total_writes, want.total_writes);
        if (out_total_reads !== want.total_reads)
          report_mismatch("total_reads", out_total_reads, want.total_reads);
        if (out_total_faults !== want.total_faults)
          report_mismatch("total_faults", out_total_faults, want.total_faults);
      end
    end
  end

  // Hits, write hits, bad process ids, a limit flush, finish and a zero limit.
  task automatic test_directed_cases();
    // The reset limit of four is in force here.
    send_request(CMD_ACCESS, PID_ONE, 20'h00000, 1'b0);
    send_request(CMD_ACCESS, PID_ONE, 20'h00000, 1'b1);
    send_request(CMD_ACCESS, PID_TWO, 20'hFFFFF, 1'b1);
    send_request(CMD_ACCESS, PID_TWO, 20'hFFFFF, 1'b0);
    send_request(CMD_ACCESS, PID_NONE, 20'hFFFFF, 1'b1);
    send_request(CMD_ACCESS, PID_BAD, 20'h00000, 1'b0);
    // The fifth fault of process one exceeds the limit and flushes its frames.
    send_request(CMD_ACCESS, PID_ONE, 20'h00001, 1'b0);
    send_request(CMD_ACCESS, PID_ONE, 20'h00002, 1'b1);
    send_request(CMD_ACCESS, PID_ONE, 20'h00004, 1'b0);
    send_request(CMD_ACCESS, PID_ONE, 20'h00008, 1'b1);
    send_request(CMD_ACCESS, PID_ONE, 20'hAAAAA, 1'b1);
    send_request(CMD_ACCESS, PID_TWO, 20'h55555, 1'b1);
    // Finish with dirty frames, then again on an empty table.
    send_request(CMD_FINISH, PID_BAD, 20'h55555, 1'b1);
    send_request(CMD_FINISH, PID_NONE, 20'hAAAAA, 1'b0);
    send_request(CMD_ACCESS, PID_TWO, 20'hFFFFF, 1'b0);
    send_request(CMD_ACCESS, PID_ONE, 20'hAAAAA, 1'b0);
    // With a zero limit every fault flushes first.
    set_fault_limit(16'h0000);
    send_request(CMD_ACCESS, PID_TWO, 20'h12345, 1'b1);
    send_request(CMD_ACCESS, PID_TWO, 20'h6789A, 1'b0);
    send_request(CMD_ACCESS, PID_TWO, 20'h6789A, 1'b1);
    send_request(CMD_ACCESS, PID_ONE, 20'hFEDCB, 1'b1);
    set_fault_limit(16'hFFFF);
    send_request(CMD_ACCESS, PID_ONE, 20'hFEDCB, 1'b0);
  endtask

  // Fills the whole table so that faults find no free frame, then flushes it.
  task automatic test_table_exhaustion();
    logic [PAGE_W-1:0] resident [$];
    logic [PAGE_W-1:0] page;
    int i;
    set_fault_limit(16'hFFFF);
    send_request(CMD_FINISH, PID_ONE, 20'h00000, 1'b0);
    for (i = 0; i < FRAMES + 8; i++) begin
      page = PAGE_W'($urandom);
      resident.push_back(page);
      send_request(CMD_ACCESS, PID_ONE, page, 1'b1);
    end
    no_idle = 1'b1;
    for (i = 0; i < 6; i++)
      send_request(CMD_ACCESS, PID_TWO, PAGE_W'($urandom), 1'($urandom_range(0, 1)));
    for (i = 0; i < 10; i++)
      send_request(CMD_ACCESS, PID_ONE, resident[$urandom_range(0, FRAMES - 1)],
                   1'($urandom_range(0, 1)));
    no_idle = 1'b0;
    send_request(CMD_FINISH, PID_TWO, PAGE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Phases of mostly well-formed accesses on small page pools under varied limits.
  task automatic test_random_traffic();
    logic [PAGE_W-1:0] pool [12];
    logic [LIMIT_W-1:0] limit;
    int phase;
    int i;
    int r;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: limit = 16'd1;
        1: limit = 16'hFFFF;
        2: limit = 16'd0;
        default: limit = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom)
                                                     : LIMIT_W'($urandom_range(1, 12));
      endcase
      set_fault_limit(limit);
      for (i = 0; i < 12; i++) pool[i] = PAGE_W'($urandom);
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_request(CMD_FINISH, PID_W'($urandom_range(0, 3)), PAGE_W'($urandom),
                       1'($urandom_range(0, 1)));
        end else if (r < 6) begin
          send_request(CMD_ACCESS, ($urandom_range(0, 1) == 0) ? PID_NONE : PID_BAD,
                       PAGE_W'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          send_request(CMD_ACCESS, ($urandom_range(0, 1) == 0) ? PID_ONE : PID_TWO,
                       ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 11)]
                                                    : PAGE_W'($urandom),
                       1'($urandom_range(0, 1)));
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Reset, the tests in turn, then the verdict.
  initial begin
    clear_shadow_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_table_exhaustion();
    test_random_traffic();
    wait_quiet(2 * FRAMES + 8);
    if (mismatch_count == 0) begin
      $display("inverted_page_table_fault_flush_core: match");
    end else begin
      $display("inverted_page_table_fault_flush_core: mismatch");
    end
    $finish;
  end

endmodule
